@@ rtl/core/bie_pkg.sv @@
package bie_pkg;

  localparam int unsigned MemBytesDef  = 65536;
  localparam int unsigned CallDepthDef = 64;
  localparam int unsigned TryDepthDef  = 16;

  localparam int unsigned InW  = 80;
  localparam int unsigned OutW = 120;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_PANIC   = 8'he0;
  localparam logic [7:0] OP_TRY     = 8'he1;
  localparam logic [7:0] OP_TRYEND  = 8'he2;
  localparam logic [7:0] OP_MOV     = 8'hd0;
  localparam logic [7:0] OP_MOVI    = 8'hd1;
  localparam logic [7:0] OP_MOVIB   = 8'hd2;
  localparam logic [7:0] OP_LOAD    = 8'hd3;
  localparam logic [7:0] OP_LOADB   = 8'hd4;
  localparam logic [7:0] OP_STORE   = 8'hd5;
  localparam logic [7:0] OP_STOREB  = 8'hd6;
  localparam logic [7:0] OP_PUSH    = 8'hd7;
  localparam logic [7:0] OP_POP     = 8'hd8;
  localparam logic [7:0] OP_JMP     = 8'hf0;
  localparam logic [7:0] OP_JNZ     = 8'hf1;
  localparam logic [7:0] OP_CALL    = 8'hf2;
  localparam logic [7:0] OP_RET     = 8'hf3;
  localparam logic [7:0] OP_SYSCALL = 8'hf4;
  localparam logic [7:0] OP_CMP     = 8'hc0;
  localparam logic [7:0] OP_ISEQ    = 8'hc1;
  localparam logic [7:0] OP_ISLT    = 8'hc2;
  localparam logic [7:0] OP_ISGT    = 8'hc3;
  localparam logic [7:0] OP_ISLE    = 8'hc4;
  localparam logic [7:0] OP_ISGE    = 8'hc5;
  localparam logic [7:0] OP_ISNE    = 8'hc6;
  localparam logic [7:0] OP_FCMP    = 8'hc7;
  localparam logic [7:0] OP_FLAST   = 8'hcf;
  localparam logic [7:0] OP_ADD     = 8'ha0;
  localparam logic [7:0] OP_SUB     = 8'ha1;
  localparam logic [7:0] OP_MUL     = 8'ha2;
  localparam logic [7:0] OP_DIV     = 8'ha3;
  localparam logic [7:0] OP_REM     = 8'ha4;
  localparam logic [7:0] OP_FADD    = 8'ha5;
  localparam logic [7:0] OP_FDIV    = 8'ha8;
  localparam logic [7:0] OP_AND     = 8'hb0;
  localparam logic [7:0] OP_OR      = 8'hb1;
  localparam logic [7:0] OP_XOR     = 8'hb2;
  localparam logic [7:0] OP_NOT     = 8'hb3;

  localparam logic [1:0] RS_RUN  = 2'd0;
  localparam logic [1:0] RS_HALT = 2'd1;
  localparam logic [1:0] RS_SYS  = 2'd2;

  localparam logic [2:0] TC_NONE  = 3'd0;
  localparam logic [2:0] TC_OPC   = 3'd1;
  localparam logic [2:0] TC_FLOAT = 3'd2;
  localparam logic [2:0] TC_ADDR  = 3'd3;
  localparam logic [2:0] TC_DIV0  = 3'd4;
  localparam logic [2:0] TC_PANIC = 3'd5;
  localparam logic [2:0] TC_STACK = 3'd6;
  localparam logic [2:0] TC_REG   = 3'd7;

  localparam logic [2:0] RI_SP = 3'd0;
  localparam logic [2:0] RI_ST = 3'd1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_EXEC, S_MRD, S_MWR, S_MD, S_STK, S_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic div;
    logic rem;
  } md_req_t;

endpackage

@@ rtl/core/bie_muldiv.sv @@
module bie_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bie_pkg::md_req_t req_i,
  input  logic [63:0]      opa_i,
  input  logic [63:0]      opb_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  import bie_pkg::*;

  logic        busy_q, fin_q, done_q, div_q, rem_q, neg_q;
  logic [5:0]  cnt_q;
  logic [63:0] x_q, y_q, d_q, res_q;
  logic [63:0] ua, ub, t, val;
  logic [64:0] add_a, add_b, sum;
  logic        cin, ge;

  always_comb begin
    ua = opa_i[63] ? (64'd0 - opa_i) : opa_i;
    ub = opb_i[63] ? (64'd0 - opb_i) : opb_i;
    t  = {x_q[62:0], y_q[63]};
    if (div_q) begin
      add_a = {1'b0, t};
      add_b = {1'b1, ~d_q};
      cin   = 1'b1;
    end else begin
      add_a = {1'b0, x_q};
      add_b = {1'b0, (y_q[0] ? d_q : 64'd0)};
      cin   = 1'b0;
    end
    sum = add_a + add_b + {64'd0, cin};
    ge  = ~sum[64];
    val = (div_q && !rem_q) ? y_q : x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      cnt_q <= 6'd0;
      div_q <= req_i.div;
      rem_q <= req_i.rem;
      x_q   <= 64'd0;
      y_q   <= req_i.div ? ua : opb_i;
      d_q   <= req_i.div ? ub : opa_i;
      neg_q <= req_i.div & (req_i.rem ? opa_i[63] : (opa_i[63] ^ opb_i[63]));
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (div_q) begin
        x_q <= ge ? sum[63:0] : t;
        y_q <= {y_q[62:0], ge};
      end else begin
        x_q <= sum[63:0];
        d_q <= {d_q[62:0], 1'b0};
        y_q <= {1'b0, y_q[63:1]};
      end
    end else if (fin_q) begin
      res_q <= neg_q ? (64'd0 - val) : val;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/core/bytecode_instruction_execute_core.sv @@
// Executes one bytecode instruction per transfer on the input stream and
// returns one result transfer per instruction on the output stream.
// The input tdata carries the opcode, the register byte and the 64-bit
// immediate; the output tdata carries the next instruction pointer, run
// status, trap cause, syscall number and the register write, if any.
// The core takes one instruction at a time and holds tready low while it
// works. A result is shown in the output register, and tready returns in
// that same cycle. Byte loads, word loads and pop, and byte stores, word
// stores and push step byte by byte through the byte-wide data memory,
// and ret or panic pass through a further state for the stack memory
// read. Multiply, divide and remainder run on a shared bit-serial unit.
// After reset the data memory is swept to zero, one byte per cycle, so
// the input is not ready until the sweep is done. A stalled receiver
// leaves the result in the output register; the next instruction is
// still accepted and executed, and its result waits until that register
// empties.
// A trap halts the core: later instructions only report the halted state.
module bytecode_instruction_execute_core #(
  parameter int unsigned MEM_BYTES  = bie_pkg::MemBytesDef,
  parameter int unsigned CALL_DEPTH = bie_pkg::CallDepthDef,
  parameter int unsigned TRY_DEPTH  = bie_pkg::TryDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: mode, reg_byte, immediate.
  input  logic [bie_pkg::InW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Fields from bit 0 up: next_ip, run_status, trap_cause, syscall_number,
  // write_valid, write_index, write_value, then zero fill.
  output logic [bie_pkg::OutW-1:0]  m_axis_tdata
);
  import bie_pkg::*;

  localparam int unsigned AW  = $clog2(MEM_BYTES);
  localparam int unsigned RDW = $clog2(CALL_DEPTH + 1);
  localparam int unsigned RIW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int unsigned HDW = $clog2(TRY_DEPTH + 1);
  localparam int unsigned HIW = (TRY_DEPTH > 1) ? $clog2(TRY_DEPTH) : 1;
  localparam int unsigned HEW = 32 + RDW;
  localparam logic [63:0] SpReset = 64'(MEM_BYTES);
  localparam logic [63:0] WordLim = 64'(MEM_BYTES - 8);
  localparam logic [AW-1:0] ClrLast = AW'(MEM_BYTES - 1);

  logic [7:0]  in_mode, in_rb;
  logic [63:0] in_imm;
  assign in_mode = s_axis_tdata[7:0];
  assign in_rb   = s_axis_tdata[15:8];
  assign in_imm  = s_axis_tdata[79:16];

  state_e            state_q, state_d;
  logic              halt_q, halt_d;
  logic [31:0]       pc_q, pc_d;
  logic [RDW-1:0]    rdepth_q, rdepth_d, rdec;
  logic [HDW-1:0]    hdepth_q, hdepth_d, hdec;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              m_tvalid_q, m_tvalid_d;
  logic [OutW-1:0]   m_tdata_q, m_tdata_d;

  logic [7:0]        mode_q, mode_d, rb_q, rb_d;
  logic [63:0]       imm_q, imm_d;
  logic [3:0]        cnt_q, cnt_d, len_q, len_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [63:0]       wdata_q, wdata_d, acc_q, acc_d;
  logic [31:0]       res_ip_q, res_ip_d;
  logic [1:0]        res_st_q, res_st_d;
  logic [2:0]        res_trap_q, res_trap_d;
  logic [7:0]        res_sys_q, res_sys_d;
  logic              res_wv_q, res_wv_d;
  logic [2:0]        res_wi_q, res_wi_d;
  logic [63:0]       res_wval_q, res_wval_d;

  logic [63:0]       rf_mem [8];
  logic [7:0]        rf_vld_q;
  logic [2:0]        rd_ia, rd_ib, rf_wi;
  logic [63:0]       rda_q, rdb_q, rf_wd;
  logic              rf_we;

  logic [7:0]        dmem [MEM_BYTES];
  logic              dm_we;
  logic [AW-1:0]     dm_wa, dm_ra;
  logic [7:0]        dm_wd, mem_rd_q;

  logic [31:0]       rs_mem [CALL_DEPTH];
  logic              rs_we;
  logic [RIW-1:0]    rs_wa, rs_ra;
  logic [31:0]       rs_wd, rs_rd_q;

  logic [HEW-1:0]    hs_mem [TRY_DEPTH];
  logic              hs_we;
  logic [HIW-1:0]    hs_wa, hs_ra;
  logic [HEW-1:0]    hs_wd, hs_rd_q;

  md_req_t           md_req;
  logic              md_done;
  logic [63:0]       md_res;

  logic [63:0]       spn, shifted;

  assign rdec    = rdepth_q - RDW'(1);
  assign hdec    = hdepth_q - HDW'(1);
  assign spn     = rda_q - 64'd8;
  assign shifted = {mem_rd_q, acc_q[63:8]};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  always_comb begin
    rd_ia = in_rb[2:0];
    rd_ib = in_rb[6:4];
    unique case (in_mode) inside
      OP_PUSH: begin
        rd_ia = RI_SP;
        rd_ib = in_rb[2:0];
      end
      OP_POP: rd_ia = RI_SP;
      OP_JNZ, [OP_ISEQ:OP_ISNE]: rd_ia = RI_ST;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wi] <= rf_wd;
    end
    rda_q <= rf_vld_q[rd_ia] ? rf_mem[rd_ia] : ((rd_ia == RI_SP) ? SpReset : 64'd0);
    rdb_q <= rf_vld_q[rd_ib] ? rf_mem[rd_ib] : ((rd_ib == RI_SP) ? SpReset : 64'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_wi] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    mem_rd_q <= dmem[dm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= rs_wd;
    end
    rs_rd_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hs_we) begin
      hs_mem[hs_wa] <= hs_wd;
    end
    hs_rd_q <= hs_mem[hs_ra];
  end

  bie_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .opa_i  (rda_q),
    .opb_i  (rdb_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  always_comb begin
    logic [2:0]  trap;
    logic [31:0] nxt;
    logic [63:0] ld_val;
    logic        z, n, cres;

    state_d    = state_q;
    halt_d     = halt_q;
    pc_d       = pc_q;
    rdepth_d   = rdepth_q;
    hdepth_d   = hdepth_q;
    clr_cnt_d  = clr_cnt_q;
    m_tvalid_d = m_tvalid_q & ~m_axis_tready;
    m_tdata_d  = m_tdata_q;
    mode_d     = mode_q;
    rb_d       = rb_q;
    imm_d      = imm_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    addr_d     = addr_q;
    wdata_d    = wdata_q;
    acc_d      = acc_q;
    res_ip_d   = res_ip_q;
    res_st_d   = res_st_q;
    res_trap_d = res_trap_q;
    res_sys_d  = res_sys_q;
    res_wv_d   = res_wv_q;
    res_wi_d   = res_wi_q;
    res_wval_d = res_wval_q;
    rf_we      = 1'b0;
    rf_wi      = res_wi_q;
    rf_wd      = res_wval_q;
    dm_we      = 1'b0;
    dm_wa      = addr_q + AW'(cnt_q);
    dm_ra      = addr_q + AW'(cnt_q);
    dm_wd      = wdata_q[7:0];
    rs_we      = 1'b0;
    rs_wa      = rdepth_q[RIW-1:0];
    rs_ra      = rdec[RIW-1:0];
    rs_wd      = pc_q + 32'd9;
    hs_we      = 1'b0;
    hs_wa      = hdepth_q[HIW-1:0];
    hs_ra      = hdec[HIW-1:0];
    hs_wd      = {imm_q[31:0], rdepth_q};
    md_req     = '0;
    trap       = TC_NONE;
    nxt        = pc_q;
    ld_val     = '0;
    z          = (rda_q == 64'd0);
    n          = rda_q[63];
    cres       = 1'b0;

    unique case (state_q)
      S_CLR: begin
        dm_we = 1'b1;
        dm_wa = clr_cnt_q;
        dm_wd = 8'd0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d     = in_mode;
          rb_d       = in_rb;
          imm_d      = in_imm;
          res_ip_d   = pc_q;
          res_st_d   = halt_q ? RS_HALT : RS_RUN;
          res_trap_d = TC_NONE;
          res_sys_d  = '0;
          res_wv_d   = 1'b0;
          res_wi_d   = '0;
          res_wval_d = '0;
          state_d    = halt_q ? S_FIN : S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FIN;
        cnt_d   = '0;
        unique case (mode_q) inside
          OP_NOP: nxt = pc_q + 32'd1;
          OP_PANIC: begin
            if (hdepth_q == '0) begin
              trap = TC_PANIC;
            end else begin
              hdepth_d = hdec;
              state_d  = S_STK;
            end
          end
          OP_TRY: begin
            if (hdepth_q >= HDW'(TRY_DEPTH)) begin
              trap = TC_STACK;
            end else begin
              hs_we    = 1'b1;
              hdepth_d = hdepth_q + HDW'(1);
              nxt      = pc_q + 32'd9;
            end
          end
          OP_TRYEND: begin
            if (hdepth_q == '0) begin
              trap = TC_STACK;
            end else begin
              hdepth_d = hdec;
              nxt      = pc_q + 32'd1;
            end
          end
          OP_MOV, OP_CMP, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
            if (rb_q[3] || rb_q[7]) begin
              trap = TC_REG;
            end else begin
              res_wv_d = 1'b1;
              res_wi_d = rb_q[2:0];
              nxt      = pc_q + 32'd2;
              case (mode_q)
                OP_MOV: res_wval_d = rdb_q;
                OP_CMP: begin
                  res_wi_d   = RI_ST;
                  res_wval_d = rda_q - rdb_q;
                end
                OP_ADD: res_wval_d = rda_q + rdb_q;
                OP_SUB: res_wval_d = rda_q - rdb_q;
                OP_AND: res_wval_d = rda_q & rdb_q;
                OP_OR:  res_wval_d = rda_q | rdb_q;
                default: res_wval_d = rda_q ^ rdb_q;
              endcase
            end
          end
          OP_MOVI, OP_MOVIB, OP_NOT: begin
            if (rb_q[3]) begin
              trap = TC_REG;
            end else begin
              res_wv_d = 1'b1;
              res_wi_d = rb_q[2:0];
              case (mode_q)
                OP_MOVI: begin
                  res_wval_d = imm_q;
                  nxt        = pc_q + 32'd10;
                end
                OP_MOVIB: begin
                  res_wval_d = {56'd0, imm_q[7:0]};
                  nxt        = pc_q + 32'd3;
                end
                default: begin
                  res_wval_d = ~rda_q;
                  nxt        = pc_q + 32'd2;
                end
              endcase
            end
          end
          OP_LOAD, OP_LOADB: begin
            if (rb_q[3] || rb_q[7]) begin
              trap = TC_REG;
            end else if ((mode_q == OP_LOAD) ? (rdb_q > WordLim) : (rdb_q >= SpReset)) begin
              trap = TC_ADDR;
            end else begin
              addr_d  = rdb_q[AW-1:0];
              len_d   = (mode_q == OP_LOAD) ? 4'd8 : 4'd1;
              nxt     = pc_q + 32'd2;
              state_d = S_MRD;
            end
          end
          OP_STORE, OP_STOREB: begin
            if (rb_q[3] || rb_q[7]) begin
              trap = TC_REG;
            end else if ((mode_q == OP_STORE) ? (rda_q > WordLim) : (rda_q >= SpReset)) begin
              trap = TC_ADDR;
            end else begin
              addr_d  = rda_q[AW-1:0];
              wdata_d = rdb_q;
              len_d   = (mode_q == OP_STORE) ? 4'd8 : 4'd1;
              nxt     = pc_q + 32'd2;
              state_d = S_MWR;
            end
          end
          OP_PUSH: begin
            if (rb_q[3]) begin
              trap = TC_REG;
            end else if (rda_q < 64'd8 || rda_q > SpReset) begin
              trap = TC_STACK;
            end else begin
              addr_d     = spn[AW-1:0];
              wdata_d    = (rb_q[2:0] == RI_SP) ? spn : rdb_q;
              len_d      = 4'd8;
              res_wv_d   = 1'b1;
              res_wi_d   = RI_SP;
              res_wval_d = spn;
              nxt        = pc_q + 32'd2;
              state_d    = S_MWR;
            end
          end
          OP_POP: begin
            if (rb_q[3]) begin
              trap = TC_REG;
            end else if (rda_q > WordLim) begin
              trap = TC_STACK;
            end else begin
              addr_d  = rda_q[AW-1:0];
              len_d   = 4'd8;
              nxt     = pc_q + 32'd2;
              state_d = S_MRD;
              if (rb_q[2:0] != RI_SP) begin
                rf_we = 1'b1;
                rf_wi = RI_SP;
                rf_wd = rda_q + 64'd8;
              end
            end
          end
          OP_JMP: nxt = imm_q[31:0];
          OP_JNZ: nxt = z ? (pc_q + 32'd9) : imm_q[31:0];
          OP_CALL: begin
            if (rdepth_q >= RDW'(CALL_DEPTH)) begin
              trap = TC_STACK;
            end else begin
              rs_we    = 1'b1;
              rdepth_d = rdepth_q + RDW'(1);
              nxt      = imm_q[31:0];
            end
          end
          OP_RET: begin
            if (rdepth_q == '0) begin
              trap = TC_STACK;
            end else begin
              rdepth_d = rdec;
              state_d  = S_STK;
            end
          end
          OP_SYSCALL: begin
            nxt       = pc_q + 32'd2;
            res_st_d  = RS_SYS;
            res_sys_d = rb_q;
          end
          [OP_ISEQ:OP_ISNE]: begin
            case (mode_q)
              OP_ISEQ: cres = z;
              OP_ISLT: cres = n;
              OP_ISGT: cres = !n && !z;
              OP_ISLE: cres = n || z;
              OP_ISGE: cres = !n;
              default: cres = !z;
            endcase
            res_wv_d   = 1'b1;
            res_wi_d   = RI_ST;
            res_wval_d = {63'd0, cres};
            nxt        = pc_q + 32'd1;
          end
          OP_MUL, OP_DIV, OP_REM: begin
            if (rb_q[3] || rb_q[7]) begin
              trap = TC_REG;
            end else if (mode_q != OP_MUL && rdb_q == 64'd0) begin
              trap = TC_DIV0;
            end else begin
              md_req.start = 1'b1;
              md_req.div   = (mode_q != OP_MUL);
              md_req.rem   = (mode_q == OP_REM);
              nxt          = pc_q + 32'd2;
              state_d      = S_MD;
            end
          end
          [OP_FADD:OP_FDIV], [OP_FCMP:OP_FLAST]: trap = TC_FLOAT;
          default: trap = TC_OPC;
        endcase
        if (trap != TC_NONE) begin
          res_st_d   = RS_HALT;
          res_trap_d = trap;
          res_ip_d   = pc_q;
          state_d    = S_FIN;
        end else begin
          res_ip_d = nxt;
        end
      end

      S_MRD: begin
        if (cnt_q != 4'd0) begin
          acc_d = shifted;
        end
        if (cnt_q == len_q) begin
          ld_val = (len_q == 4'd8) ? shifted : {56'd0, shifted[63:56]};
          if (mode_q == OP_POP && rb_q[2:0] == RI_SP) begin
            ld_val = ld_val + 64'd8;
          end
          res_wv_d   = 1'b1;
          res_wi_d   = rb_q[2:0];
          res_wval_d = ld_val;
          state_d    = S_FIN;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end

      S_MWR: begin
        dm_we   = 1'b1;
        wdata_d = {8'd0, wdata_q[63:8]};
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == len_q - 4'd1) begin
          state_d = S_FIN;
        end
      end

      S_MD: begin
        if (md_done) begin
          res_wv_d   = 1'b1;
          res_wi_d   = rb_q[2:0];
          res_wval_d = md_res;
          state_d    = S_FIN;
        end
      end

      S_STK: begin
        if (mode_q == OP_PANIC) begin
          rdepth_d = hs_rd_q[RDW-1:0];
          res_ip_d = hs_rd_q[HEW-1:RDW];
        end else begin
          res_ip_d = rs_rd_q;
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {7'd0, res_wval_q, res_wi_q, res_wv_q, res_sys_q,
                        res_trap_q, res_st_q, res_ip_q};
          rf_we      = res_wv_q;
          if (res_trap_q != TC_NONE) begin
            halt_d = 1'b1;
          end
          pc_d    = res_ip_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      halt_q     <= 1'b0;
      pc_q       <= '0;
      rdepth_q   <= '0;
      hdepth_q   <= '0;
      clr_cnt_q  <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      halt_q     <= halt_d;
      pc_q       <= pc_d;
      rdepth_q   <= rdepth_d;
      hdepth_q   <= hdepth_d;
      clr_cnt_q  <= clr_cnt_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tdata_q  <= m_tdata_d;
    mode_q     <= mode_d;
    rb_q       <= rb_d;
    imm_q      <= imm_d;
    cnt_q      <= cnt_d;
    len_q      <= len_d;
    addr_q     <= addr_d;
    wdata_q    <= wdata_d;
    acc_q      <= acc_d;
    res_ip_q   <= res_ip_d;
    res_st_q   <= res_st_d;
    res_trap_q <= res_trap_d;
    res_sys_q  <= res_sys_d;
    res_wv_q   <= res_wv_d;
    res_wi_q   <= res_wi_d;
    res_wval_q <= res_wval_d;
  end

endmodule

@@ rtl/core/bie_checker.sv @@
module bie_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [bie_pkg::InW-1:0]   s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [bie_pkg::OutW-1:0]  m_axis_tdata
);
  import bie_pkg::*;

  logic unused_in;
  assign unused_in = ^s_axis_tdata;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while an instruction was in flight.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed.");

  a_trap_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[36:34] != TC_NONE |->
      m_axis_tdata[33:32] == RS_HALT && !m_axis_tdata[45])
    else $error("Trap reported without a halt or with a register write.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3 &&
      (m_axis_tdata[33:32] == RS_SYS || m_axis_tdata[44:37] == 8'd0))
    else $error("Bad run status or stray syscall number.");

endmodule

bind bytecode_instruction_execute_core bie_checker u_bie_checker (.*);

@@ tb/sv/bytecode_instruction_execute_core_tb.sv @@
module bytecode_instruction_execute_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bie_pkg::*;

  localparam int unsigned MemBytes = MemBytesDef;

  typedef struct packed {
    logic [63:0] wval;
    logic [2:0]  widx;
    logic        wvalid;
    logic [7:0]  sysno;
    logic [2:0]  cause;
    logic [1:0]  status;
    logic [31:0] nip;
  } outcome_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OutW-1:0]  m_axis_tdata;

  bytecode_instruction_execute_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Machine state as the block should hold it.
  logic [63:0] regs_q [8];
  logic [7:0]  dmem_q [MemBytes];
  logic [31:0] pc_q;
  logic [31:0] ret_stack_q [CallDepthDef];
  int unsigned ret_depth_q;
  logic [31:0] catch_ip_q [TryDepthDef];
  int unsigned catch_rdepth_q [TryDepthDef];
  int unsigned try_depth_q;
  logic [1:0]  mach_state_q;

  outcome_t    pending_q[$];
  int unsigned failures;
  int unsigned hold_cycles;
  bit          sender_quiet;
  bit          receiver_quiet;
  outcome_t    got_res;
  outcome_t    want_res;

  function automatic logic [63:0] read_word(input logic [63:0] addr);
    logic [63:0] v;
    v = '0;
    for (int i = 7; i >= 0; i--) v = {v[55:0], dmem_q[addr + i]};
    return v;
  endfunction

  // Executes one instruction on the predicted state. With commit cleared the
  // state is left untouched, so a candidate can be checked for a trap.
  function automatic void exec_insn(input logic [7:0] op, input logic [7:0] rb,
                                    input logic [63:0] imm, input bit commit,
                                    output outcome_t res);
    logic [3:0]  r1, r2;
    logic [31:0] nxt, tgt;
    logic [2:0]  cause;
    logic [1:0]  st;
    bit          wr, bad1, bad2, sp_set, push_ret, push_try, z, n, c, an, bn;
    logic [2:0]  widx;
    logic [63:0] wv, a, b, ua, ub, q, sp_val, mw_addr, mw_data;
    int unsigned mw_kind, n_rd, n_hd;
    r1 = rb[3:0];
    r2 = rb[7:4];
    bad1 = r1 > 7;
    bad2 = r2 > 7;
    tgt = imm[31:0];
    nxt = pc_q;
    cause = TC_NONE;
    st = RS_RUN;
    wr = 0;
    widx = '0;
    wv = '0;
    sp_set = 0;
    sp_val = '0;
    push_ret = 0;
    push_try = 0;
    mw_kind = 0;
    mw_addr = '0;
    mw_data = '0;
    n_rd = ret_depth_q;
    n_hd = try_depth_q;
    res = '0;
    if (mach_state_q == RS_HALT) begin
      res.nip = pc_q;
      res.status = RS_HALT;
      return;
    end
    case (op)
      OP_NOP: nxt = pc_q + 1;
      OP_PANIC: begin
        if (try_depth_q == 0) cause = TC_PANIC;
        else begin
          n_hd = try_depth_q - 1;
          n_rd = catch_rdepth_q[n_hd];
          nxt = catch_ip_q[n_hd];
        end
      end
      OP_TRY: begin
        if (try_depth_q >= TryDepthDef) cause = TC_STACK;
        else begin
          push_try = 1;
          n_hd = try_depth_q + 1;
          nxt = pc_q + 9;
        end
      end
      OP_TRYEND: begin
        if (try_depth_q == 0) cause = TC_STACK;
        else begin
          n_hd = try_depth_q - 1;
          nxt = pc_q + 1;
        end
      end
      OP_MOV: begin
        if (bad1 || bad2) cause = TC_REG;
        else begin
          wr = 1; widx = r1[2:0]; wv = regs_q[r2[2:0]]; nxt = pc_q + 2;
        end
      end
      OP_MOVI: begin
        if (bad1) cause = TC_REG;
        else begin
          wr = 1; widx = r1[2:0]; wv = imm; nxt = pc_q + 10;
        end
      end
      OP_MOVIB: begin
        if (bad1) cause = TC_REG;
        else begin
          wr = 1; widx = r1[2:0]; wv = {56'd0, imm[7:0]}; nxt = pc_q + 3;
        end
      end
      OP_LOAD, OP_LOADB: begin
        if (bad1 || bad2) cause = TC_REG;
        else begin
          a = regs_q[r2[2:0]];
          if (op == OP_LOAD && a > MemBytes - 8) cause = TC_ADDR;
          else if (op == OP_LOADB && a >= MemBytes) cause = TC_ADDR;
          else begin
            wr = 1;
            widx = r1[2:0];
            wv = (op == OP_LOAD) ? read_word(a) : {56'd0, dmem_q[a]};
            nxt = pc_q + 2;
          end
        end
      end
      OP_STORE, OP_STOREB: begin
        if (bad1 || bad2) cause = TC_REG;
        else begin
          a = regs_q[r1[2:0]];
          if (op == OP_STORE && a > MemBytes - 8) cause = TC_ADDR;
          else if (op == OP_STOREB && a >= MemBytes) cause = TC_ADDR;
          else begin
            mw_kind = (op == OP_STORE) ? 1 : 2;
            mw_addr = a;
            mw_data = regs_q[r2[2:0]];
            nxt = pc_q + 2;
          end
        end
      end
      OP_PUSH: begin
        a = regs_q[RI_SP];
        if (bad1) cause = TC_REG;
        else if (a < 8 || a > MemBytes) cause = TC_STACK;
        else begin
          mw_kind = 1;
          mw_addr = a - 8;
          mw_data = (r1 == 0) ? a - 8 : regs_q[r1[2:0]];
          wr = 1; widx = RI_SP; wv = a - 8; nxt = pc_q + 2;
        end
      end
      OP_POP: begin
        a = regs_q[RI_SP];
        if (bad1) cause = TC_REG;
        else if (a > MemBytes - 8) cause = TC_STACK;
        else begin
          b = read_word(a);
          wr = 1;
          widx = r1[2:0];
          if (r1 == 0) wv = b + 8;
          else begin
            wv = b; sp_set = 1; sp_val = a + 8;
          end
          nxt = pc_q + 2;
        end
      end
      OP_JMP: nxt = tgt;
      OP_JNZ: nxt = (regs_q[RI_ST] != 0) ? tgt : pc_q + 9;
      OP_CALL: begin
        if (ret_depth_q >= CallDepthDef) cause = TC_STACK;
        else begin
          push_ret = 1; n_rd = ret_depth_q + 1; nxt = tgt;
        end
      end
      OP_RET: begin
        if (ret_depth_q == 0) cause = TC_STACK;
        else begin
          n_rd = ret_depth_q - 1; nxt = ret_stack_q[n_rd];
        end
      end
      OP_SYSCALL: begin
        nxt = pc_q + 2; st = RS_SYS;
      end
      OP_CMP: begin
        if (bad1 || bad2) cause = TC_REG;
        else begin
          wr = 1; widx = RI_ST; wv = regs_q[r1[2:0]] - regs_q[r2[2:0]]; nxt = pc_q + 2;
        end
      end
      OP_ISEQ, OP_ISLT, OP_ISGT, OP_ISLE, OP_ISGE, OP_ISNE: begin
        z = regs_q[RI_ST] == 0;
        n = regs_q[RI_ST][63];
        case (op)
          OP_ISEQ: c = z;
          OP_ISLT: c = n;
          OP_ISGT: c = !n && !z;
          OP_ISLE: c = n || z;
          OP_ISGE: c = !n;
          default: c = !z;
        endcase
        wr = 1; widx = RI_ST; wv = {63'd0, c}; nxt = pc_q + 1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR: begin
        if (bad1 || bad2) cause = TC_REG;
        else begin
          a = regs_q[r1[2:0]];
          b = regs_q[r2[2:0]];
          an = a[63];
          bn = b[63];
          ua = an ? -a : a;
          ub = bn ? -b : b;
          case (op)
            OP_ADD: wv = a + b;
            OP_SUB: wv = a - b;
            OP_MUL: wv = a * b;
            OP_AND: wv = a & b;
            OP_OR:  wv = a | b;
            OP_XOR: wv = a ^ b;
            default: begin
              if (b == 0) cause = TC_DIV0;
              else if (op == OP_DIV) begin
                q = ua / ub;
                wv = (an != bn) ? -q : q;
              end else begin
                q = ua % ub;
                wv = an ? -q : q;
              end
            end
          endcase
          wr = 1; widx = r1[2:0]; nxt = pc_q + 2;
        end
      end
      OP_NOT: begin
        if (bad1) cause = TC_REG;
        else begin
          wr = 1; widx = r1[2:0]; wv = ~regs_q[r1[2:0]]; nxt = pc_q + 2;
        end
      end
      default: begin
        if (op inside {[OP_FADD:OP_FDIV], [OP_FCMP:OP_FLAST]}) cause = TC_FLOAT;
        else cause = TC_OPC;
      end
    endcase

    if (cause != TC_NONE) begin
      res.nip = pc_q;
      res.status = RS_HALT;
      res.cause = cause;
      if (commit) mach_state_q = RS_HALT;
      return;
    end
    res.nip = nxt;
    res.status = st;
    res.sysno = (st == RS_SYS) ? rb : 8'd0;
    res.wvalid = wr;
    res.widx = wr ? widx : 3'd0;
    res.wval = wr ? wv : 64'd0;
    if (!commit) return;
    if (mw_kind == 1) for (int i = 0; i < 8; i++) dmem_q[mw_addr + i] = mw_data[8*i +: 8];
    if (mw_kind == 2) dmem_q[mw_addr] = mw_data[7:0];
    if (push_ret) ret_stack_q[ret_depth_q] = pc_q + 9;
    if (push_try) begin
      catch_ip_q[try_depth_q] = tgt;
      catch_rdepth_q[try_depth_q] = ret_depth_q;
    end
    ret_depth_q = n_rd;
    try_depth_q = n_hd;
    if (sp_set) regs_q[RI_SP] = sp_val;
    if (wr) regs_q[widx] = wv;
    pc_q = nxt;
    mach_state_q = st;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #12ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: random short stalls, rare long ones, and forced hold-offs.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (receiver_quiet) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        hold_cycles = $urandom_range(15, 60);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 9) > 2);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata[$bits(outcome_t)-1:0];
      if (pending_q.size() == 0) begin
        $error("result transfer with no expected result: %h", got_res);
        failures++;
      end else begin
        want_res = pending_q.pop_front();
        if (got_res.nip !== want_res.nip) begin
          $error("next_ip expected %h actual %h", want_res.nip, got_res.nip);
          failures++;
        end
        if (got_res.status !== want_res.status) begin
          $error("run_status expected %0d actual %0d", want_res.status, got_res.status);
          failures++;
        end
        if (got_res.cause !== want_res.cause) begin
          $error("trap_cause expected %0d actual %0d", want_res.cause, got_res.cause);
          failures++;
        end
        if (got_res.sysno !== want_res.sysno) begin
          $error("syscall_number expected %h actual %h", want_res.sysno, got_res.sysno);
          failures++;
        end
        if (got_res.wvalid !== want_res.wvalid) begin
          $error("write_valid expected %b actual %b", want_res.wvalid, got_res.wvalid);
          failures++;
        end
        if (got_res.widx !== want_res.widx) begin
          $error("write_index expected %0d actual %0d", want_res.widx, got_res.widx);
          failures++;
        end
        if (got_res.wval !== want_res.wval) begin
          $error("write_value expected %h actual %h", want_res.wval, got_res.wval);
          failures++;
        end
      end
    end
  end

  task automatic send_insn(input logic [7:0] op, input logic [7:0] rb, input logic [63:0] imm);
    int unsigned gap, r;
    bit ok;
    outcome_t res;
    gap = 0;
    if (!sender_quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {imm, rb, op};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    exec_insn(op, rb, imm, 1'b1, res);
    pending_q.push_back(res);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_insn(OP_NOP, 8'h00, '0);
    send_insn(OP_MOVI, 8'h02, 64'h8000_0000_0000_0000);
    send_insn(OP_MOVI, 8'h03, 64'hffff_ffff_ffff_ffff);
    send_insn(OP_MOV, 8'h24, '0);
    send_insn(OP_DIV, 8'h32, '0);
    send_insn(OP_MOV, 8'h42, '0);
    send_insn(OP_REM, 8'h34, '0);
    send_insn(OP_MOVI, 8'h05, 64'h7fff_ffff_ffff_ffff);
    send_insn(OP_ADD, 8'h55, '0);
    send_insn(OP_MUL, 8'h35, '0);
    send_insn(OP_SUB, 8'h25, '0);
    send_insn(OP_MOVIB, 8'hf6, 64'h1234_5678_9abc_deff);
    send_insn(OP_MOVI, 8'h07, 64'(MemBytes - 8));
    send_insn(OP_STORE, 8'h57, '0);
    send_insn(OP_LOAD, 8'h76, '0);
    send_insn(OP_STOREB, 8'h67, '0);
    send_insn(OP_LOADB, 8'h74, '0);
    send_insn(OP_PUSH, 8'h05, '0);
    send_insn(OP_PUSH, 8'h00, '0);
    send_insn(OP_POP, 8'h00, '0);
    send_insn(OP_POP, 8'h04, '0);
    send_insn(OP_CMP, 8'h54, '0);
    send_insn(OP_ISEQ, 8'hff, '0);
    send_insn(OP_ISLT, 8'h80, '0);
    send_insn(OP_ISGT, 8'h00, '0);
    send_insn(OP_ISLE, 8'h00, '0);
    send_insn(OP_ISGE, 8'h00, '0);
    send_insn(OP_ISNE, 8'h00, '0);
    send_insn(OP_JNZ, 8'h00, 64'hdead_beef_0000_0040);
    send_insn(OP_AND, 8'h45, '0);
    send_insn(OP_OR, 8'h45, '0);
    send_insn(OP_XOR, 8'h23, '0);
    send_insn(OP_NOT, 8'h06, '0);
    send_insn(OP_CALL, 8'h00, 64'h0000_0000_0000_1000);
    send_insn(OP_TRY, 8'h00, 64'h0000_0000_0000_2000);
    send_insn(OP_CALL, 8'h00, 64'h0000_0000_ffff_fff8);
    send_insn(OP_PANIC, 8'h00, '0);
    send_insn(OP_RET, 8'h00, '0);
    send_insn(OP_TRY, 8'h00, 64'h0000_0000_0000_3000);
    send_insn(OP_TRYEND, 8'h00, '0);
    send_insn(OP_SYSCALL, 8'hff, '0);
    send_insn(OP_JMP, 8'h00, 64'h0000_0000_ffff_fffe);
    send_insn(OP_NOP, 8'h00, '0);
    send_insn(OP_NOP, 8'h00, '0);
  endtask

  localparam logic [7:0] LegalOps [29] = '{
    OP_NOP, OP_PANIC, OP_TRY, OP_TRYEND, OP_MOV, OP_MOVI, OP_MOVIB, OP_LOAD, OP_LOADB,
    OP_STORE, OP_STOREB, OP_PUSH, OP_POP, OP_JMP, OP_JNZ, OP_CALL, OP_RET, OP_SYSCALL,
    OP_CMP, OP_ISEQ, OP_ISLT, OP_ISGT, OP_ISLE, OP_ISGE, OP_ISNE, OP_ADD, OP_SUB,
    OP_MUL, OP_DIV
  };

  localparam logic [7:0] MoreOps [5] = '{OP_REM, OP_AND, OP_OR, OP_XOR, OP_NOT};

  // Random instructions that keep the machine running: a candidate that
  // would trap is dropped and a new one drawn.
  task automatic test_random(input int unsigned count);
    logic [7:0]  op, rb;
    logic [63:0] imm;
    outcome_t    trial;
    for (int unsigned k = 0; k < count; k++) begin
      do begin
        case ($urandom_range(0, 9))
          0, 1: op = OP_MOVI;
          2: op = MoreOps[$urandom_range(0, 4)];
          default: op = LegalOps[$urandom_range(0, 28)];
        endcase
        rb = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8) rb[7] = 1'b0;
        if ($urandom_range(0, 9) < 8) rb[3] = 1'b0;
        imm = {$urandom, $urandom};
        if (op == OP_MOVI && $urandom_range(0, 1)) begin
          imm = 64'($urandom_range(0, MemBytes - 1));
        end
        if (op inside {OP_CALL, OP_TRY, OP_JMP} && $urandom_range(0, 1)) begin
          imm[31:0] = $urandom_range(0, 4095);
        end
        exec_insn(op, rb, imm, 1'b0, trial);
      end while (trial.status == RS_HALT);
      send_insn(op, rb, imm);
    end
  endtask

  task automatic test_backpressure();
    sender_quiet = 1;
    hold_cycles = 400;
    test_random(12);
    sender_quiet = 0;
    wait_results();
  endtask

  // One trap is all a single reset allows; the cause is chosen at random.
  task automatic test_trap_halt();
    logic [7:0] fop;
    case ($urandom_range(1, 7))
      1: send_insn(8'h01, 8'($urandom_range(0, 255)), {$urandom, $urandom});
      2: begin
        fop = $urandom_range(0, 1) ? 8'($urandom_range(OP_FADD, OP_FDIV))
                                   : 8'($urandom_range(OP_FCMP, OP_FLAST));
        send_insn(fop, 8'h00, '0);
      end
      3: begin
        send_insn(OP_MOVI, 8'h02, 64'(MemBytes));
        send_insn(OP_LOADB, 8'h23, '0);
      end
      4: begin
        send_insn(OP_MOVI, 8'h03, '0);
        send_insn(OP_DIV, 8'h32, '0);
      end
      5: begin
        while (try_depth_q > 0) send_insn(OP_TRYEND, 8'h00, '0);
        send_insn(OP_PANIC, 8'h00, '0);
      end
      6: begin
        while (try_depth_q > 0) send_insn(OP_TRYEND, 8'h00, '0);
        send_insn(OP_TRYEND, 8'h00, '0);
      end
      default: send_insn(OP_ADD, 8'h28, '0);
    endcase
    for (int i = 0; i < 6; i++) send_insn(LegalOps[$urandom_range(0, 28)], 8'h00, '0);
  endtask

  initial begin
    failures = 0;
    hold_cycles = 0;
    sender_quiet = 0;
    receiver_quiet = 0;
    foreach (regs_q[i]) regs_q[i] = '0;
    regs_q[RI_SP] = 64'(MemBytes);
    foreach (dmem_q[i]) dmem_q[i] = '0;
    foreach (ret_stack_q[i]) ret_stack_q[i] = '0;
    foreach (catch_ip_q[i]) catch_ip_q[i] = '0;
    foreach (catch_rdepth_q[i]) catch_rdepth_q[i] = 0;
    pc_q = '0;
    ret_depth_q = 0;
    try_depth_q = 0;
    mach_state_q = RS_RUN;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500);
    sender_quiet = 1;
    receiver_quiet = 1;
    test_random(150);
    sender_quiet = 0;
    receiver_quiet = 0;
    test_backpressure();
    test_random(400);
    wait_results();
    test_random(450);
    test_trap_halt();
    wait_results();
    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
